// File: sv/vecn_pkg.sv
package vecn_pkg;

    // width of the norm result field
    localparam int NORM_BITS = 24;

    // largest norm that fits the result field
    localparam logic [NORM_BITS-1:0] NORM_MAX = {NORM_BITS{1'b1}};

    // entries in the queue between accumulator and square root unit
    localparam int QUEUE_DEPTH = 2;

    // square root sequencer states
    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_RUN,
        SQ_HOLD
    } sqrt_state_t;

endpackage

// File: sv/vecn_front.sv
module vecn_front
    import vecn_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_BITS    = 48
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [SAMPLE_BITS-1:0] element,
    input  logic                          last_element,
    input  logic                          push,
    output logic                          full,
    output logic                          q_push,
    output logic [ACC_BITS:0]             q_data,
    input  logic                          q_full
);

    localparam int SQ_BITS  = 2 * SAMPLE_BITS;
    localparam int SUM_BITS = ((ACC_BITS > SQ_BITS) ? ACC_BITS : SQ_BITS) + 1;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s1_last_reg;
    logic [SQ_BITS-1:0]     sq_reg;
    logic [ACC_BITS-1:0]    sum_reg;
    logic [ACC_BITS-1:0]    sum_next;
    logic                   sat_reg;
    logic                   sat_next;
    logic [SAMPLE_BITS-1:0] element_u;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SUM_BITS-1:0]    sum_wide;
    logic                   ovf;
    logic [ACC_BITS-1:0]    acc_new;
    logic                   sat_new;
    logic                   adv;
    logic                   take;

    // the pipe holds only when a finished vector cannot enter the queue
    assign adv  = !(s1_valid_reg && s1_last_reg && q_full);
    assign full = !adv;
    assign take = push && adv;

    // magnitude of the element, the most negative value maps to its unsigned pattern
    assign element_u = unsigned'(element);
    assign mag       = element_u[SAMPLE_BITS-1] ? (~element_u + 1'b1) : element_u;

    // square stage
    always_ff @(posedge clk)
    begin
        if (adv && take)
        begin
            sq_reg      <= SQ_BITS'(mag) * SQ_BITS'(mag);
            s1_last_reg <= last_element;
        end
    end

    assign s1_valid_next = adv ? take : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // saturating accumulate
    assign sum_wide = SUM_BITS'(sum_reg) + SUM_BITS'(sq_reg);
    assign ovf      = |sum_wide[SUM_BITS-1:ACC_BITS];
    assign acc_new  = ovf ? {ACC_BITS{1'b1}} : sum_wide[ACC_BITS-1:0];
    assign sat_new  = sat_reg | ovf;

    // hand the finished sum to the queue and start a new vector
    assign q_push = adv && s1_valid_reg && s1_last_reg;
    assign q_data = {sat_new, acc_new};

    always_comb
    begin
        sum_next = sum_reg;
        sat_next = sat_reg;
        if (adv && s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                sum_next = '0;
                sat_next = 1'b0;
            end
            else
            begin
                sum_next = acc_new;
                sat_next = sat_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            sat_reg <= sat_next;
        end
    end

    // a finished vector only enters a queue with room
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("front pushes into a full queue");

endmodule

// File: sv/vecn_queue.sv
module vecn_queue
    import vecn_pkg::*;
#(
    parameter int WIDTH = 49
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: sv/vecn_sqrt.sv
module vecn_sqrt
    import vecn_pkg::*;
#(
    parameter int ACC_BITS = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  logic [ACC_BITS:0]    q_data,
    output logic                 q_pop,
    output logic [NORM_BITS-1:0] norm,
    output logic                 overflowed,
    output logic                 empty,
    input  logic                 pop
);

    localparam int RW       = ACC_BITS + (ACC_BITS % 2);
    localparam int STEPS    = RW / 2;
    localparam int CNT_BITS = $clog2(STEPS);

    sqrt_state_t          state_reg;
    sqrt_state_t          state_next;
    logic [RW-1:0]        v_reg;
    logic [RW-1:0]        v_next;
    logic [RW-1:0]        root_reg;
    logic [RW-1:0]        root_next;
    logic [RW-1:0]        bit_reg;
    logic [RW-1:0]        bit_next;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [CNT_BITS-1:0]  cnt_next;
    logic                 flag_reg;
    logic                 flag_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [NORM_BITS-1:0] norm_reg;
    logic [NORM_BITS-1:0] norm_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic [RW-1:0]        trial;
    logic                 fits;
    logic                 too_wide;

    assign trial    = root_reg + bit_reg;
    assign fits     = (v_reg >= trial);
    assign too_wide = (root_reg > RW'(NORM_MAX));

    assign norm       = norm_reg;
    assign overflowed = ovf_reg;
    assign empty      = !out_valid_reg;

    // digit-by-digit square root sequencer, one result bit per cycle
    always_comb
    begin
        state_next     = state_reg;
        v_next         = v_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        cnt_next       = cnt_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg;
        norm_next      = norm_reg;
        ovf_next       = ovf_reg;
        q_pop          = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            SQ_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    v_next     = RW'(q_data[ACC_BITS-1:0]);
                    flag_next  = q_data[ACC_BITS];
                    root_next  = '0;
                    bit_next   = {2'b01, {(RW - 2){1'b0}}};
                    cnt_next   = '0;
                    state_next = SQ_RUN;
                end
            end
            SQ_RUN:
            begin
                if (fits)
                begin
                    v_next    = v_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(STEPS - 1))
                begin
                    state_next = SQ_HOLD;
                end
            end
            SQ_HOLD:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    norm_next      = too_wide ? NORM_MAX : root_reg[NORM_BITS-1:0];
                    ovf_next       = flag_reg | too_wide;
                    state_next     = SQ_IDLE;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        cnt_reg  <= cnt_next;
        flag_reg <= flag_next;
        norm_reg <= norm_next;
        ovf_reg  <= ovf_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SQ_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // the sequencer only takes work that is there
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("square root unit pops an empty queue");

    // after the final step the root waits for the output register
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SQ_RUN && cnt_reg == CNT_BITS'(STEPS - 1)) |=> state_reg == SQ_HOLD)
        else $error("square root did not finish after its last step");

endmodule

// File: sv/vector_euclidean_norm.sv
// Streaming Euclidean norm of a signed fixed-point vector.
// Input channel: push/full. One element per cycle is taken while full is low;
// last_element marks the final element of a vector. Each element is squared,
// registered, and added into a saturating accumulator ACC_BITS wide.
// Result channel: empty/pop. While empty is low, norm holds the floor square
// root of the vector's sum of squares and overflowed is set if the sum
// saturated or the root does not fit 24 bits; pop takes it.
// From the last element to its result the path runs through one square stage,
// one accumulate stage that writes the queue, a load of
// the root unit, an iterative square root that resolves one root bit per
// cycle (ACC_BITS/2 steps, rounded up) and the fill of the output register.
// Elements stream at one per cycle while full is low; finished vectors are handed
// to the square root unit through a two-entry queue, and the root unit takes
// a new sum only once it has delivered the previous result.
// When the receiver stalls, the result waits in the output register, the
// root unit holds its next result, then the queue fills and full rises only
// once a last element cannot be handed over.
// Reset clears the accumulator, the overflow flag and the queue, and empties the output register.
module vector_euclidean_norm
    import vecn_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_BITS    = 48
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [SAMPLE_BITS-1:0] element,
    input  logic                          last_element,
    input  logic                          push,
    output logic                          full,
    output logic [NORM_BITS-1:0]          norm,
    output logic                          overflowed,
    output logic                          empty,
    input  logic                          pop
);

    logic                q_push;
    logic [ACC_BITS:0]   q_wr_data;
    logic                q_full;
    logic                q_pop;
    logic [ACC_BITS:0]   q_rd_data;
    logic                q_empty;

    // square and accumulate
    vecn_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .element      (element),
        .last_element (last_element),
        .push         (push),
        .full         (full),
        .q_push       (q_push),
        .q_data       (q_wr_data),
        .q_full       (q_full)
    );

    // finished sums waiting for the root unit
    vecn_queue #(
        .WIDTH (ACC_BITS + 1)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // square root and result register
    vecn_sqrt #(
        .ACC_BITS (ACC_BITS)
    ) u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_rd_data),
        .q_pop      (q_pop),
        .norm       (norm),
        .overflowed (overflowed),
        .empty      (empty),
        .pop        (pop)
    );

endmodule
